### src/pearson_correlation_matrix_unit_assert.svh
// Assertion macros for the correlation matrix unit.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef PEARSON_CORRELATION_MATRIX_UNIT_ASSERT_SVH
`define PEARSON_CORRELATION_MATRIX_UNIT_ASSERT_SVH

// same-cycle implication
`define PCM_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pcm assertion failed");

// next-cycle implication
`define PCM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pcm assertion failed");

`endif

### src/pcm_pkg.sv
// Shared constants, types and state encodings for the correlation matrix unit.
// No dependencies.
`default_nettype none
package pcm_pkg;

  localparam int MAX_COLUMNS = 8;
  localparam int MAX_SAMPLES = 1024;
  localparam int COL_W       = $clog2(MAX_COLUMNS);
  localparam int IDX_W       = $clog2(MAX_SAMPLES);
  localparam int CNT_W       = IDX_W + 1;
  localparam int ADDR_W      = COL_W + IDX_W;
  localparam int SAMPLE_W    = 16;
  localparam int PROD_W      = 2 * SAMPLE_W;
  localparam int SUM_W       = SAMPLE_W + IDX_W + 1;
  localparam int ACC_W       = PROD_W + IDX_W;
  localparam int WIDE_W      = 56;
  localparam int VAR_W       = 52;
  localparam int ROOT_W      = VAR_W;
  localparam int RAD_W       = 2 * VAR_W;
  localparam int STEP_W      = 6;
  localparam int FRAC_BITS   = 14;
  localparam int COEF_W      = 16;
  localparam int CFG_W       = 4;
  localparam int TDATA_IN_W  = 24;
  localparam int TDATA_OUT_W = 24;
  localparam int TUSER_IN_W  = 2;

  localparam logic [CFG_W-1:0]         CFG_RESET = CFG_W'(2);
  localparam logic signed [COEF_W-1:0] Q_ONE     = COEF_W'(16384);

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_COMPUTE = 1'b1;
  localparam logic ERR_NONE   = 1'b0;
  localparam logic ERR_FEW    = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_PAIR, ST_ACC, ST_FIN, ST_EMIT
  } state_e;

  typedef enum logic [2:0] {
    FS_IDLE, FS_MULT, FS_PROD, FS_SQRT, FS_CHECK, FS_DIV, FS_DONE
  } fin_state_e;

  typedef struct packed {
    logic signed [SUM_W-1:0] sx;
    logic signed [SUM_W-1:0] sy;
    logic signed [ACC_W-1:0] sxy;
    logic signed [ACC_W-1:0] sxx;
    logic signed [ACC_W-1:0] syy;
  } sums_t;

  typedef struct packed {
    logic busy;
    logic done;
  } fin_status_t;

endpackage
`default_nettype wire

### src/pcm_sample_ram.sv
// Sample store: one write port, two registered read ports.
// Depends on pcm_pkg.
`default_nettype none
module pcm_sample_ram (
  input  wire logic                         clk_i,
  input  wire logic                         we_i,
  input  wire logic [pcm_pkg::ADDR_W-1:0]   waddr_i,
  input  wire logic [pcm_pkg::SAMPLE_W-1:0] wdata_i,
  input  wire logic [pcm_pkg::ADDR_W-1:0]   raddr_a_i,
  input  wire logic [pcm_pkg::ADDR_W-1:0]   raddr_b_i,
  output logic      [pcm_pkg::SAMPLE_W-1:0] rdata_a_o,
  output logic      [pcm_pkg::SAMPLE_W-1:0] rdata_b_o
);
  import pcm_pkg::*;

  logic [SAMPLE_W-1:0] mem_q [MAX_COLUMNS*MAX_SAMPLES];
  logic [SAMPLE_W-1:0] rdata_a_q, rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule
`default_nettype wire

### src/pcm_corr_finish.sv
// Coefficient finisher: numerator/variances, serial product, bit-serial
// square root and restoring fractional divide. Depends on pcm_pkg.
`default_nettype none
module pcm_corr_finish (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start_i,
  input  wire logic [pcm_pkg::CNT_W-1:0]        n_i,
  input  wire pcm_pkg::sums_t                   sums_i,
  output pcm_pkg::fin_status_t                  status_o,
  output logic signed [pcm_pkg::COEF_W-1:0]     coef_o
);
  import pcm_pkg::*;

  fin_state_e fs_q, fs_d;
  logic [1:0]        ph_q, ph_d;
  logic [STEP_W-1:0] step_q, step_d;

  logic signed [WIDE_W-1:0] t1_q, t2_q, num_q, diff, num_abs;
  logic [VAR_W-1:0]  varx_q, mplier_q, mag_q;
  logic [RAD_W-1:0]  mcand_q, prod_q, rad_q, prod_add;
  logic [ROOT_W:0]   rem_q, rem_next;
  logic [ROOT_W+2:0] rem_sh, trial, rem_diff;
  logic [ROOT_W-1:0] root_q, root_next, r_q, r_next, r_diff;
  logic [ROOT_W:0]   r2;
  logic [FRAC_BITS-1:0] q_q, q_next;
  logic neg_q, sq_ge, dv_ge;
  logic signed [COEF_W-1:0] coef_q;

  logic signed [ACC_W-1:0]        opa;
  logic signed [SUM_W-1:0]        sa, sb;
  logic signed [CNT_W+ACC_W:0]    m1;
  logic signed [2*SUM_W-1:0]      m2;

  always_comb begin
    unique case (ph_q)
      2'd1:    begin opa = sums_i.sxx; sa = sums_i.sx; sb = sums_i.sx; end
      2'd2:    begin opa = sums_i.syy; sa = sums_i.sy; sb = sums_i.sy; end
      default: begin opa = sums_i.sxy; sa = sums_i.sx; sb = sums_i.sy; end
    endcase
    m1 = $signed({1'b0, n_i}) * opa;
    m2 = sa * sb;
    diff    = t1_q - t2_q;
    num_abs = num_q[WIDE_W-1] ? -num_q : num_q;

    prod_add = prod_q + (mplier_q[0] ? mcand_q : '0);

    rem_sh    = {rem_q, rad_q[RAD_W-1 -: 2]};
    trial     = {1'b0, root_q, 2'b01};
    sq_ge     = rem_sh >= trial;
    rem_diff  = rem_sh - trial;
    rem_next  = sq_ge ? rem_diff[ROOT_W:0] : rem_sh[ROOT_W:0];
    root_next = {root_q[ROOT_W-2:0], sq_ge};

    r2     = {r_q, 1'b0};
    dv_ge  = r2 >= {1'b0, root_q};
    r_diff = ROOT_W'(r2 - {1'b0, root_q});
    r_next = dv_ge ? r_diff : r2[ROOT_W-1:0];
    q_next = {q_q[FRAC_BITS-2:0], dv_ge};
  end

  always_comb begin
    fs_d = fs_q;
    ph_d = '0;
    unique case (fs_q)
      FS_IDLE:  if (start_i) fs_d = FS_MULT;
      FS_MULT: begin
        ph_d = ph_q + 2'd1;
        if (ph_q == 2'd3) fs_d = FS_PROD;
      end
      FS_PROD:  if (step_q == STEP_W'(VAR_W - 1)) fs_d = FS_SQRT;
      FS_SQRT:  if (step_q == STEP_W'(ROOT_W - 1)) fs_d = FS_CHECK;
      FS_CHECK: begin
        if (root_q == '0 || mag_q >= root_q) fs_d = FS_DONE;
        else fs_d = FS_DIV;
      end
      FS_DIV:   if (step_q == STEP_W'(FRAC_BITS - 1)) fs_d = FS_DONE;
      FS_DONE:  fs_d = FS_IDLE;
      default:  fs_d = FS_IDLE;
    endcase
    step_d = (fs_d != fs_q) ? '0 : step_q + STEP_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fs_q   <= FS_IDLE;
      ph_q   <= '0;
      step_q <= '0;
    end else begin
      fs_q   <= fs_d;
      ph_q   <= ph_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (fs_q)
      FS_MULT: begin
        t1_q <= WIDE_W'(m1);
        t2_q <= WIDE_W'(m2);
        if (ph_q == 2'd1) num_q <= diff;
        if (ph_q == 2'd2) varx_q <= diff[VAR_W-1:0];
        if (ph_q == 2'd3) begin
          mplier_q <= diff[VAR_W-1:0];
          mcand_q  <= RAD_W'(varx_q);
          prod_q   <= '0;
          mag_q    <= num_abs[VAR_W-1:0];
          neg_q    <= num_q[WIDE_W-1];
        end
      end
      FS_PROD: begin
        prod_q   <= prod_add;
        mcand_q  <= mcand_q << 1;
        mplier_q <= mplier_q >> 1;
        rad_q    <= prod_add;
        rem_q    <= '0;
        root_q   <= '0;
      end
      FS_SQRT: begin
        rem_q  <= rem_next;
        root_q <= root_next;
        rad_q  <= rad_q << 2;
      end
      FS_CHECK: begin
        r_q <= mag_q;
        q_q <= '0;
        if (root_q == '0) coef_q <= '0;
        else if (mag_q >= root_q) coef_q <= neg_q ? -Q_ONE : Q_ONE;
      end
      FS_DIV: begin
        r_q <= r_next;
        q_q <= q_next;
        coef_q <= neg_q ? -$signed({2'b00, q_next}) : $signed({2'b00, q_next});
      end
      default: ;
    endcase
  end

  assign status_o.busy = (fs_q != FS_IDLE);
  assign status_o.done = (fs_q == FS_DONE);
  assign coef_o        = coef_q;

endmodule
`default_nettype wire

### src/pearson_correlation_matrix_unit.sv
// Correlation matrix unit: column sample loading and matrix sequencing.
// Depends on pcm_pkg, pcm_sample_ram, pcm_corr_finish and the assert header.
//
// Input stream: tuser[0] = 0 loads one Q8.8 sample into column tdata[2:0];
// tuser[1] marks it missing (dropped). Full columns ignore further loads.
// tuser[0] = 1 runs the matrix over columns_in_use columns (cfg_wdata_i,
// written with cfg_we_i while idle, reset value 2, values above 8 act as 8).
// Output stream: one request per matrix entry in row order, tlast on the
// final one; fewer than two columns gives a single request with tuser set.
// Loads are taken one per cycle while idle. A compute request takes each
// diagonal, empty or mismatched entry straight to output; an off-diagonal
// pair of n-sample columns runs dual-port reads over all n samples and
// pipeline drain, then the multiply phases, 52 serial product steps, 52
// square-root steps, one check and up to 14 divide steps in the finisher.
// Input is held off during a run.
// A stalled receiver holds the output register and pauses the run.
// Reset clears all column counts and the pipeline; stored samples persist
// but are unreachable until rewritten.
`default_nettype none
`include "pearson_correlation_matrix_unit_assert.svh"
module pearson_correlation_matrix_unit (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [pcm_pkg::CFG_W-1:0]         cfg_wdata_i,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // column_index[2:0], sample_value[18:3], zero pad
  input  wire logic [pcm_pkg::TDATA_IN_W-1:0]    s_axis_tdata,
  // operation[0], sample_is_nan[1]
  input  wire logic [pcm_pkg::TUSER_IN_W-1:0]    s_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // row_index[2:0], col_index[5:3], coefficient[21:6], zero pad
  output logic [pcm_pkg::TDATA_OUT_W-1:0]        m_axis_tdata,
  // error_code[0]
  output logic                                   m_axis_tuser,
  output logic                                   m_axis_tlast
);
  import pcm_pkg::*;

  state_e state_q, state_d;
  logic [CFG_W-1:0] cols_cfg_q, n_use_q, n_use_d;
  logic [CNT_W-1:0] cnt_q [MAX_COLUMNS];
  logic [COL_W-1:0] i_q, i_d, j_q, j_d, cnt_sel, in_col;
  logic [CNT_W-1:0] rd_cnt, ni_q, ni_d, k_q, k_d;
  logic s_fire, in_op, in_nan, load_we, issuing, fin_start;
  logic last_col, last_row;
  logic v1_q, v2_q;
  logic signed [SAMPLE_W-1:0] xa_q, yb_q;
  logic signed [PROD_W-1:0]   pxy_q, pxx_q, pyy_q;
  sums_t sums_q;
  logic [SAMPLE_W-1:0] rdata_a, rdata_b, in_val;
  logic signed [COEF_W-1:0] res_coef_q, res_coef_d, fin_coef;
  logic res_err_q, res_err_d;
  logic out_v_q, out_v_d, out_load;
  logic [COL_W-1:0] out_row_q, out_col_q;
  logic signed [COEF_W-1:0] out_coef_q;
  logic out_err_q, out_last_q;
  logic clr_sums;
  fin_status_t fin_st;

  assign in_col  = s_axis_tdata[COL_W-1:0];
  assign in_val  = s_axis_tdata[COL_W +: SAMPLE_W];
  assign in_op   = s_axis_tuser[0];
  assign in_nan  = s_axis_tuser[1];
  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_fire  = s_axis_tvalid && s_axis_tready;

  assign last_col = (CFG_W'(j_q) + CFG_W'(1)) == n_use_q;
  assign last_row = (CFG_W'(i_q) + CFG_W'(1)) == n_use_q;

  always_comb begin
    unique case (state_q)
      ST_IDLE: cnt_sel = (in_op == OP_COMPUTE) ? '0 : in_col;
      ST_EMIT: cnt_sel = last_col ? i_q + COL_W'(1) : i_q;
      default: cnt_sel = j_q;
    endcase
  end
  assign rd_cnt  = cnt_q[cnt_sel];
  assign load_we = s_fire && (in_op == OP_LOAD) && !in_nan && !rd_cnt[CNT_W-1];

  assign issuing = (state_q == ST_ACC) && (k_q != ni_q);

  pcm_sample_ram u_ram (
    .clk_i     (clk_i),
    .we_i      (load_we),
    .waddr_i   ({in_col, rd_cnt[IDX_W-1:0]}),
    .wdata_i   (in_val),
    .raddr_a_i ({i_q, k_q[IDX_W-1:0]}),
    .raddr_b_i ({j_q, k_q[IDX_W-1:0]}),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  pcm_corr_finish u_fin (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (fin_start),
    .n_i      (ni_q),
    .sums_i   (sums_q),
    .status_o (fin_st),
    .coef_o   (fin_coef)
  );

  always_comb begin
    state_d    = state_q;
    n_use_d    = n_use_q;
    i_d        = i_q;
    j_d        = j_q;
    ni_d       = ni_q;
    k_d        = k_q;
    res_coef_d = res_coef_q;
    res_err_d  = res_err_q;
    fin_start  = 1'b0;
    clr_sums   = 1'b0;
    out_load   = 1'b0;
    out_v_d    = out_v_q && !m_axis_tready;
    unique case (state_q)
      ST_IDLE: begin
        if (s_fire && in_op == OP_COMPUTE) begin
          n_use_d = (cols_cfg_q > CFG_W'(MAX_COLUMNS)) ? CFG_W'(MAX_COLUMNS) : cols_cfg_q;
          i_d  = '0;
          j_d  = '0;
          ni_d = rd_cnt;
          if (n_use_d < CFG_W'(2)) begin
            res_coef_d = '0;
            res_err_d  = ERR_FEW;
            state_d    = ST_EMIT;
          end else begin
            res_err_d = ERR_NONE;
            state_d   = ST_PAIR;
          end
        end
      end
      ST_PAIR: begin
        if (i_q == j_q) begin
          res_coef_d = Q_ONE;
          state_d    = ST_EMIT;
        end else if (ni_q != rd_cnt || ni_q == '0) begin
          res_coef_d = '0;
          state_d    = ST_EMIT;
        end else begin
          k_d      = '0;
          clr_sums = 1'b1;
          state_d  = ST_ACC;
        end
      end
      ST_ACC: begin
        if (issuing) k_d = k_q + CNT_W'(1);
        if (!issuing && !v1_q && !v2_q) begin
          fin_start = 1'b1;
          state_d   = ST_FIN;
        end
      end
      ST_FIN: begin
        if (fin_st.done) begin
          res_coef_d = fin_coef;
          state_d    = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_v_q || m_axis_tready) begin
          out_load = 1'b1;
          out_v_d  = 1'b1;
          if (res_err_q == ERR_FEW || (last_col && last_row)) begin
            state_d = ST_IDLE;
          end else begin
            state_d = ST_PAIR;
            if (last_col) begin
              j_d  = '0;
              i_d  = i_q + COL_W'(1);
              ni_d = rd_cnt;
            end else begin
              j_d = j_q + COL_W'(1);
            end
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cols_cfg_q <= CFG_RESET;
      n_use_q    <= CFG_RESET;
      i_q        <= '0;
      j_q        <= '0;
      ni_q       <= '0;
      k_q        <= '0;
      v1_q       <= 1'b0;
      v2_q       <= 1'b0;
      out_v_q    <= 1'b0;
      res_err_q  <= ERR_NONE;
      for (int c = 0; c < MAX_COLUMNS; c++) cnt_q[c] <= '0;
    end else begin
      state_q   <= state_d;
      n_use_q   <= n_use_d;
      i_q       <= i_d;
      j_q       <= j_d;
      ni_q      <= ni_d;
      k_q       <= k_d;
      v1_q      <= issuing;
      v2_q      <= v1_q;
      out_v_q   <= out_v_d;
      res_err_q <= res_err_d;
      if (cfg_we_i) cols_cfg_q <= cfg_wdata_i;
      if (load_we) cnt_q[in_col] <= rd_cnt + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    res_coef_q <= res_coef_d;
    xa_q  <= $signed(rdata_a);
    yb_q  <= $signed(rdata_b);
    pxy_q <= $signed(rdata_a) * $signed(rdata_b);
    pxx_q <= $signed(rdata_a) * $signed(rdata_a);
    pyy_q <= $signed(rdata_b) * $signed(rdata_b);
    if (clr_sums) begin
      sums_q <= '0;
    end else if (v2_q) begin
      sums_q.sx  <= sums_q.sx  + SUM_W'(xa_q);
      sums_q.sy  <= sums_q.sy  + SUM_W'(yb_q);
      sums_q.sxy <= sums_q.sxy + ACC_W'(pxy_q);
      sums_q.sxx <= sums_q.sxx + ACC_W'(pxx_q);
      sums_q.syy <= sums_q.syy + ACC_W'(pyy_q);
    end
    if (out_load) begin
      out_row_q  <= i_q;
      out_col_q  <= j_q;
      out_coef_q <= res_coef_q;
      out_err_q  <= res_err_q;
      out_last_q <= (res_err_q == ERR_FEW) || (last_col && last_row);
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = TDATA_OUT_W'({out_coef_q, out_col_q, out_row_q});
  assign m_axis_tuser  = out_err_q;
  assign m_axis_tlast  = out_last_q;

  `PCM_ASSERT_IMPL(a_err_is_last, m_axis_tvalid && m_axis_tuser, m_axis_tlast)
  `PCM_ASSERT_IMPL(a_acc_drained, fin_start, !v1_q && !v2_q && !fin_st.busy)
  `PCM_ASSERT_IMPL(a_coef_range, fin_st.done, (fin_coef <= Q_ONE) && (fin_coef >= -Q_ONE))
  `PCM_ASSERT_NEXT(a_idle_fin, s_fire, !fin_st.busy)

endmodule
`default_nettype wire
